@@ rtl/psl_pkg.sv @@
package psl_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ATTEMPT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_RETRY_WINDOW  = 2'd1;
  localparam logic [1:0] CFG_LOCKOUT_TIME  = 2'd2;

  // request codes
  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  localparam int unsigned CntMax = 255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  attempts;
    logic [31:0] last_time;
  } entry_t;

endpackage

@@ rtl/psl_req_if.sv @@
interface psl_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] client_address;
  logic        attempt_ok;
  logic [31:0] now_seconds;

  modport source (output valid, op, client_address, attempt_ok, now_seconds, input ready);
  modport sink   (input valid, op, client_address, attempt_ok, now_seconds, output ready);
endinterface

@@ rtl/psl_rsp_if.sv @@
interface psl_rsp_if;
  logic valid;
  logic ready;
  logic blocked;
  logic table_full;

  modport source (output valid, blocked, table_full, input ready);
  modport sink   (input valid, blocked, table_full, output ready);
endinterface

@@ rtl/per_source_login_throttle.sv @@
// channel   dir  beat payload
// req_i     in   op, client_address, attempt_ok, now_seconds
// rsp_o     out  blocked, table_full
// cfg_*_i   in   write enable, register index, data (no read-back)
//
// one request at a time: entries are read one a cycle and compared in the cycle after; a
// zero address or a check with zero limit answers without a scan; the next request can be
// taken in the cycle the answer appears. reset clears the fill count but not the entries;
// entries are never freed, so the ones below it are valid and no clearing pass is needed. a
// result waiting in the output register holds the next request in its last step until that
// register is free
module per_source_login_throttle #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psl_req_if.sink     req_i,
  psl_rsp_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import psl_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] Depth = CW'(TABLE_ENTRIES);

  state_e state_q, state_d;

  logic [7:0]  limit_q;
  logic [15:0] retry_q;
  logic [15:0] lock_q;

  logic          op_q;
  logic [31:0]   addr_q;
  logic          ok_q;
  logic [31:0]   now_q;

  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          pend_q, pend_d;
  logic [IW-1:0] pend_idx_q;
  entry_t        rd_q;

  logic res_blocked_q, res_blocked_d;
  logic res_full_q, res_full_d;
  logic out_valid_q, out_valid_d;
  logic out_blocked_q, out_full_q;

  entry_t mem [TABLE_ENTRIES];

  logic          req_fire;
  logic          issue;
  logic          hit;
  logic          miss;
  logic          rd_en;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          load_out;

  logic [7:0]  base_cnt;
  logic [31:0] base_last;
  logic [7:0]  cnt0;
  logic [7:0]  new_cnt;
  logic        retry_in;
  logic        lock_in;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.blocked    = out_blocked_q;
  assign rsp_o.table_full = out_full_q;

  // scan pipeline: read issued at iss_q, compared in the cycle after
  assign issue = (state_q == ST_SCAN) && (iss_q < fill_q);
  assign hit   = (state_q == ST_SCAN) && pend_q && (rd_q.address == addr_q);
  assign miss  = (state_q == ST_SCAN) && !pend_q && !issue;
  assign rd_en = issue;

  // a new entry starts from count 0 and time 0
  assign base_cnt  = hit ? rd_q.attempts : 8'd0;
  assign base_last = hit ? rd_q.last_time : 32'd0;
  assign cnt0      = (base_cnt >= limit_q) ? 8'd0 : base_cnt;
  assign retry_in  = {1'b0, now_q} < ({1'b0, base_last} + {17'd0, retry_q});
  assign lock_in   = {1'b0, now_q} < ({1'b0, rd_q.last_time} + {17'd0, lock_q});

  always_comb begin
    if (!ok_q || retry_in) begin
      new_cnt = (cnt0 == 8'(CntMax)) ? cnt0 : cnt0 + 8'd1;
    end else begin
      new_cnt = 8'd0;
    end
  end

  assign mem_we = (op_q == OP_RECORD) && (hit || (miss && (fill_q < Depth)));
  assign mem_waddr = hit ? pend_idx_q : fill_q[IW-1:0];
  assign mem_wdata = '{address: addr_q, attempts: new_cnt, last_time: now_q};

  assign load_out = (state_q == ST_RESP) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    iss_d         = iss_q;
    pend_d        = pend_q;
    res_blocked_d = res_blocked_q;
    res_full_d    = res_full_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          res_blocked_d = 1'b0;
          res_full_d    = 1'b0;
          iss_d         = '0;
          pend_d        = 1'b0;
          if ((req_i.client_address == 32'd0) ||
              ((req_i.op == OP_CHECK) && (limit_q == 8'd0))) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit || miss) begin
          pend_d  = 1'b0;
          state_d = ST_RESP;
          if (op_q == OP_CHECK) begin
            res_blocked_d = hit && (rd_q.attempts >= limit_q) && lock_in;
          end else if (miss) begin
            if (fill_q < Depth) begin
              fill_d = fill_q + CW'(1);
            end else begin
              res_full_d = 1'b1;
            end
          end
        end else begin
          pend_d = issue;
          iss_d  = iss_q + {{(CW-1){1'b0}}, issue};
        end
      end
      ST_RESP: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fill_q        <= '0;
      iss_q         <= '0;
      pend_q        <= 1'b0;
      res_blocked_q <= 1'b0;
      res_full_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      limit_q       <= '0;
      retry_q       <= '0;
      lock_q        <= '0;
    end else begin
      state_q       <= state_d;
      fill_q        <= fill_d;
      iss_q         <= iss_d;
      pend_q        <= pend_d;
      res_blocked_q <= res_blocked_d;
      res_full_q    <= res_full_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ATTEMPT_LIMIT: limit_q <= cfg_data_i[7:0];
          CFG_RETRY_WINDOW:  retry_q <= cfg_data_i;
          CFG_LOCKOUT_TIME:  lock_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q   <= req_i.op;
      addr_q <= req_i.client_address;
      ok_q   <= req_i.attempt_ok;
      now_q  <= req_i.now_seconds;
    end
    if (issue) begin
      pend_idx_q <= iss_q[IW-1:0];
    end
    if (load_out) begin
      out_blocked_q <= res_blocked_q;
      out_full_q    <= res_full_q;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[iss_q[IW-1:0]];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Depth)
    else $error("fill count beyond table depth");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) && mem_we |=> (state_q == ST_RESP))
    else $error("write-back did not end the scan");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != ST_IDLE))
    else $error("accepted request left no work");

  a_blocked_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_blocked_q |-> !out_full_q)
    else $error("blocked and table_full in one result");

endmodule
